// File: rtl/core/assert_macros.svh
// Assertion macros used by the subband energy detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/sbed_pkg.sv
// Package with types, constants and the log helper of the subband energy detector.
`timescale 1ns / 1ps
`default_nettype none
package sbed_pkg;
  localparam int NFFT_DEF = 1024;
  localparam int NCHAN_DEF = 4;
  localparam logic [31:0] DB_K = 32'd50504453;
  localparam logic signed [15:0] DB_FLOOR = -16'sd25600;
  localparam logic signed [15:0] DB_CEIL = 16'sd25600;
  localparam logic [39:0] SUM_MAX = {40{1'b1}};

  typedef struct packed {
    logic signed [15:0] bin_re;
    logic signed [15:0] bin_im;
  } sbed_in_t;

  typedef struct packed {
    logic [1:0] channel;
    logic signed [15:0] power_db;
    logic detected;
    logic last;
  } sbed_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IIR_A, ST_IIR_B, ST_IIR_C, ST_LOG_START, ST_LOG_NORM, ST_LOG_SQ,
    ST_LOG_SQ2, ST_DB_MUL, ST_DB_DONE, ST_OUT
  } sbed_state_t;

  typedef enum logic {
    REG_DELTA = 1'b0,
    REG_ALPHA = 1'b1
  } sbed_reg_t;

  // Log2 in Q16 of a constant, with the same squaring steps as the datapath.
  function automatic int log2_q16_const(input longint unsigned x);
    int e;
    longint unsigned m;
    int fr;
    e = 63;
    fr = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return e * 65536 + fr;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/subband_energy_detector.sv
// Top level of the subband energy detector.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// A bin is taken whenever in_valid is high while a frame streams in. After the last bin
// of a frame the block is not ready until its NCHAN words have been taken. One shared
// 32x32 multiplier does all the frame-end work: the noise floor update in partial
// products (the first frame loads the floor directly instead), and each of the NCHAN+1
// log conversions, which normalizes the value, runs 16 squarings of a 32-bit mantissa
// and then the dB scaling, or gives the floor value when the value is zero. Each word is
// then held until the receiver takes it.
module subband_energy_detector
  import sbed_pkg::*;
#(
  parameter int NFFT = NFFT_DEF,
  parameter int NCHAN = NCHAN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sbed_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sbed_out_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int NSUB = NFFT / NCHAN;
  localparam int HALF = (NSUB / 2) > 0 ? (NSUB / 2) : 1;
  localparam int BW = $clog2(NFFT);
  localparam int CW = (NCHAN > 1) ? $clog2(NCHAN) : 1;
  localparam int PW = $clog2(NSUB + 1);
  localparam int HALF_L2 = log2_q16_const(64'(HALF));
  localparam int LO = NSUB / 4;
  localparam int HI = NSUB / 4 + NSUB / 2;
  localparam logic [BW-1:0] LASTB = BW'(NFFT - 1);

  logic signed [14:0] delta_r;
  logic [15:0] alpha_r;
  logic [BW-1:0] bin_r;
  logic [CW-1:0] bch_r;
  logic [PW-1:0] pos_r;
  logic [39:0] sum_r [NCHAN];
  logic [32:0] gap_r;
  logic [47:0] nf_r;
  logic nvalid_r;
  logic signed [15:0] nfdb_r;
  sbed_state_t st_r, st_nxt;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  sbed_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // sequencer registers
  logic [CW:0] idx_r;
  logic [1:0] ph_r;
  logic [2:0] step_r;
  logic [4:0] it_r;
  logic [63:0] acc_r;
  logic [47:0] x_r;
  logic [32:0] m_r;
  logic [5:0] e_r;
  logic [15:0] frac_r;
  logic signed [22:0] l_r;
  logic signed [15:0] db_r;
  logic [47:0] dbm_r;

  logic wr;
  logic [31:0] p;
  logic [31:0] re_sq, im_sq;
  logic sum_in;
  logic [40:0] sum_add;
  logic [CW-1:0] ch_idx;
  logic [47:0] log_arg;
  logic [5:0] lead;
  logic [63:0] sq;
  logic [22:0] lmag;
  logic signed [16:0] thr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (sbed_reg_t'(cfg_paddr[2]))
      REG_DELTA: cfg_prdata = 32'(signed'(delta_r));
      REG_ALPHA: cfg_prdata = {16'd0, alpha_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign re_sq = 32'(unsigned'(32'(in_data.bin_re) * 32'(in_data.bin_re)));
  assign im_sq = 32'(unsigned'(32'(in_data.bin_im) * 32'(in_data.bin_im)));
  assign p = re_sq + im_sq;
  assign in_ready = (st_r == ST_IDLE);
  assign sum_in = (bch_r < CW'(NCHAN - 1) || bch_r == CW'(NCHAN - 1))
                  && ({1'b0, bin_r} < (BW+1)'(NCHAN * NSUB))
                  && pos_r >= PW'(LO) && pos_r < PW'(HI);
  assign ch_idx = idx_r[CW-1:0];
  assign sum_add = {1'b0, sum_r[bch_r]} + 41'(p);
  assign log_arg = (idx_r == '0) ? nf_r : 48'(sum_r[ch_idx - CW'(1)]);
  assign sq = mp;
  assign lmag = l_r[22] ? 23'(-l_r) : 23'(l_r);
  assign thr = 17'(nfdb_r) + 17'(delta_r);

  always_comb begin
    lead = '0;
    for (int k = 0; k < 48; k++) begin
      if (log_arg[k]) lead = 6'(k);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (in_valid && bin_r == LASTB) st_nxt = ST_IIR_A;
      ST_IIR_A:     if (!nvalid_r) st_nxt = ST_LOG_START; else st_nxt = ST_IIR_B;
      ST_IIR_B:     if (step_r == 3'd5) st_nxt = ST_IIR_C;
      ST_IIR_C:     st_nxt = ST_LOG_START;
      ST_LOG_START: st_nxt = ST_LOG_NORM;
      ST_LOG_NORM:  st_nxt = (log_arg == '0) ? ST_DB_DONE : ST_LOG_SQ;
      ST_LOG_SQ:    st_nxt = ST_LOG_SQ2;
      ST_LOG_SQ2:   if (it_r == 5'd15) st_nxt = ST_DB_MUL; else st_nxt = ST_LOG_SQ;
      ST_DB_MUL:    if (ph_r == 2'd2) st_nxt = ST_DB_DONE;
      ST_DB_DONE:   st_nxt = (idx_r == '0) ? ST_LOG_START : ST_OUT;
      ST_OUT:       if (out_ready) st_nxt = (idx_r == (CW+1)'(NCHAN + 1)) ? ST_IDLE : ST_LOG_START;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      ST_IIR_B: begin
        case (step_r)
          3'd0: begin ma = nf_r[31:0];  mb = 32'(17'(65536) - 17'(alpha_r)); end
          3'd1: begin ma = 32'(nf_r[47:32]); mb = 32'(17'(65536) - 17'(alpha_r)); end
          3'd2: begin ma = x_r[31:0];   mb = 32'(alpha_r); end
          3'd3: begin ma = 32'(x_r[47:32]); mb = 32'(alpha_r); end
          default: ;
        endcase
      end
      ST_LOG_SQ: begin ma = m_r[31:0]; mb = m_r[31:0]; end
      ST_DB_MUL: begin ma = 32'(lmag); mb = DB_K; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      delta_r <= '0;
      alpha_r <= 16'd66;
      bin_r <= '0;
      bch_r <= '0;
      pos_r <= '0;
      gap_r <= '0;
      nf_r <= '0;
      nvalid_r <= 1'b0;
      nfdb_r <= '0;
      idx_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NCHAN; i++) sum_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr) begin
        case (sbed_reg_t'(cfg_paddr[2]))
          REG_DELTA: delta_r <= cfg_pwdata[14:0];
          REG_ALPHA: alpha_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      case (st_r)
        ST_IDLE: if (in_valid) begin
          if (sum_in) sum_r[bch_r] <= sum_add[40] ? SUM_MAX : sum_add[39:0];
          if (bin_r == BW'(NFFT / 4) || bin_r == BW'(NFFT / 4 + NFFT / 2))
            gap_r <= gap_r + 33'(p);
          if (bin_r == LASTB) begin
            bin_r <= '0; bch_r <= '0; pos_r <= '0;
            idx_r <= '0; step_r <= '0;
          end else begin
            bin_r <= bin_r + BW'(1);
            if (pos_r == PW'(NSUB - 1)) begin
              pos_r <= '0;
              bch_r <= (bch_r == CW'(NCHAN - 1)) ? bch_r : bch_r + CW'(1);
            end else pos_r <= pos_r + PW'(1);
          end
        end
        ST_IIR_A: begin
          x_r <= {gap_r[32:0], 15'd0};
          if (!nvalid_r) begin
            nf_r <= {gap_r[32:0], 15'd0};
            nvalid_r <= 1'b1;
          end
          acc_r <= 64'd32768;
        end
        ST_IIR_B: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: acc_r <= acc_r + mp;
            3'd2: acc_r <= acc_r + {mp[31:0], 32'd0};
            3'd3: acc_r <= acc_r + mp;
            3'd4: acc_r <= acc_r + {mp[31:0], 32'd0};
            default: ;
          endcase
        end
        ST_IIR_C: nf_r <= acc_r[63:16];
        ST_LOG_START: begin
          e_r <= lead;
          frac_r <= '0; it_r <= '0;
        end
        ST_LOG_NORM: begin
          if (e_r >= 6'd31) m_r <= 33'(log_arg >> (e_r - 6'd31));
          else m_r <= 33'(log_arg << (6'd31 - e_r));
          if (log_arg == '0) db_r <= DB_FLOOR;
        end
        ST_LOG_SQ: ;
        ST_LOG_SQ2: begin
          it_r <= it_r + 5'd1;
          if (sq[63]) begin
            m_r <= {1'b0, sq[63:32]};
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            m_r <= sq[63:31];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          if (it_r == 5'd15) begin
            ph_r <= '0;
            if (idx_r == '0)
              l_r <= 23'(signed'({1'b0, e_r, frac_r[14:0], sq[63]})) - 23'sd1048576;
            else
              l_r <= 23'(signed'({1'b0, e_r, frac_r[14:0], sq[63]})) - 23'(HALF_L2);
          end
        end
        ST_DB_MUL: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            dbm_r <= 48'(((mp + 64'h80000000) >> 32));
          end
          if (ph_r == 2'd2) begin
            if (l_r[22]) db_r <= (dbm_r > 48'd25600) ? DB_FLOOR : -16'(dbm_r);
            else db_r <= (dbm_r > 48'd25600) ? DB_CEIL : 16'(dbm_r);
          end
        end
        ST_DB_DONE: begin
          if (idx_r == '0) nfdb_r <= db_r;
          else begin
            out_valid <= 1'b1;
            out_data.channel <= 2'(ch_idx - CW'(1));
            out_data.power_db <= db_r;
            out_data.detected <= 17'(db_r) > thr ? 1'b1 : 1'b0;
            out_data.last <= (idx_r == (CW+1)'(NCHAN));
          end
          idx_r <= idx_r + (CW+1)'(1);
        end
        ST_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          sum_r[ch_idx - CW'(2)] <= '0;
          if (idx_r == (CW+1)'(NCHAN + 1)) gap_r <= '0;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_ready, clk, rst_n, st_r != ST_IDLE, !in_ready)
  `ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, st_r == ST_OUT)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

// File: rtl/core/sbed_mul.sv
// Shared registered 32x32 unsigned multiplier.
`timescale 1ns / 1ps
`default_nettype none
module sbed_mul
  import sbed_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire
